// ===== hdl/ffa_pkg.sv =====
// Shared types, constants and codes of the first-fit free list allocator.
`timescale 1ns / 1ps
package ffa_pkg;

    // Fixed field widths.
    localparam int ADDR_W    = 27;
    localparam int N_W       = 28;
    localparam int IDX_MAX_W = 12;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int HEADER_BYTES   = 8;

    localparam logic [ADDR_W-1:0] CEILING_RESET = 27'h7F00000;

    // Request kinds carried in tuser.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_HEAP_BASE    = 1'b0;
    localparam logic CFG_HEAP_CEILING = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED,
        ST_NEW,
        ST_OOM,
        ST_FREED,
        ST_NULL,
        ST_BAD,
        ST_FULL
    } status_t;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_REUSE,
        CM_RELEASE,
        CM_NEW
    } commit_op_t;

    // Query broadcast to every cell while a scan runs.
    typedef struct packed {
        logic              kind;
        logic [N_W-1:0]    n;
        logic [ADDR_W-1:0] a;
    } query_t;

    // Best match so far, handed from cell to cell.
    typedef struct packed {
        logic                 found;
        logic [IDX_MAX_W-1:0] pos;
        logic [IDX_MAX_W-1:0] idx;
        logic [ADDR_W-1:0]    addr;
        logic [ADDR_W-1:0]    size;
        logic                 in_use;
    } token_t;

    // State update broadcast to every cell at the end of a request.
    typedef struct packed {
        commit_op_t           op;
        logic [IDX_MAX_W-1:0] idx;
        logic [IDX_MAX_W-1:0] pos;
        logic [ADDR_W-1:0]    addr;
        logic [ADDR_W-1:0]    size;
    } commit_t;

endpackage

// ===== hdl/first_fit_free_list_allocator.sv =====
// Top level: sequencer plus a row of slot cells that scan the free list.
//
//  Channel | Valid/ready         | Payload
//  --------+---------------------+---------------------------------------------
//  request | s_tvalid/s_tready   | s_tdata, s_tuser = req_type
//  result  | m_tvalid/m_tready   | m_tdata, m_tuser = status
//  config  | cfg_wr_en           | cfg_index, cfg_wdata
//
// From acceptance to result, the match token passes through the cell row one cell
// per cycle while the scan counter runs, then the decision in S_FINISH registers
// the result.
// One request is worked on at a time; the next is taken once the result is registered.
// A stalled result holds the block in its final cycle until the output register frees.
// aresetn is synchronous and active low; slot contents need no clearing.
`timescale 1ns / 1ps
module first_fit_free_list_allocator #(
    parameter int MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [55:0]                s_tdata,   // request_bytes, release_address
    input  logic                       s_tuser,   // req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [87:0]                m_tdata,   // payload_address, granted_bytes, heap_bytes_used
    output logic [2:0]                 m_tuser,   // status
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0] cfg_wdata
);
    import ffa_pkg::*;

    localparam int UW = $clog2(MAX_BLOCKS + 1);

    query_t        query;
    commit_t       commit;
    logic [UW-1:0] slots_used;
    token_t        tok [0:MAX_BLOCKS];

    assign tok[0] = '0;

    // Request sequencer.
    ffa_ctrl #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .tok_last   (tok[MAX_BLOCKS]),
        .query      (query),
        .commit     (commit),
        .slots_used (slots_used)
    );

    // Row of slot cells.
    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        ffa_cell #(
            .MAX_BLOCKS(MAX_BLOCKS),
            .IDX       (i)
        ) u_cell (
            .aclk       (aclk),
            .query      (query),
            .commit     (commit),
            .slots_used (slots_used),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

endmodule

// ===== hdl/ffa_cell.sv =====
// One slot cell: holds a block header and its place in the free list.
`timescale 1ns / 1ps
module ffa_cell #(
    parameter int MAX_BLOCKS = 256,
    parameter int IDX        = 0,
    localparam int IW        = $clog2(MAX_BLOCKS),
    localparam int UW        = $clog2(MAX_BLOCKS + 1)
) (
    input  logic            aclk,
    input  ffa_pkg::query_t  query,
    input  ffa_pkg::commit_t commit,
    input  logic [UW-1:0]    slots_used,
    input  ffa_pkg::token_t  tok_in,
    output ffa_pkg::token_t  tok_out
);
    import ffa_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] size_reg;
    logic              in_use_reg;
    logic [IW-1:0]     pos_reg;
    token_t            tok_reg;

    logic live;
    logic fit;
    logic hit;
    logic take;
    logic tgt;
    logic [IDX_MAX_W-1:0] pos_ext;

    assign live    = UW'(IDX) < slots_used;
    assign pos_ext = IDX_MAX_W'(pos_reg);
    assign fit     = live && !in_use_reg && ({1'b0, size_reg} >= query.n);
    assign hit     = live && (addr_reg == query.a);
    assign tgt     = commit.idx == IDX_MAX_W'(IDX);

    // A free block nearer the list head wins an allocate; the lowest slot wins a release.
    always_comb begin
        if (query.kind == REQ_ALLOC) begin
            take = fit && (!tok_in.found || pos_ext < tok_in.pos);
        end else begin
            take = hit && !tok_in.found;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge aclk) begin
        if (take) begin
            tok_reg.found  <= 1'b1;
            tok_reg.pos    <= pos_ext;
            tok_reg.idx    <= IDX_MAX_W'(IDX);
            tok_reg.addr   <= addr_reg;
            tok_reg.size   <= size_reg;
            tok_reg.in_use <= in_use_reg;
        end else begin
            tok_reg <= tok_in;
        end
    end

    assign tok_out = tok_reg;

    // Header and list position updates.
    always_ff @(posedge aclk) begin
        unique case (commit.op)
            CM_REUSE: begin
                if (tgt) begin
                    in_use_reg <= 1'b1;
                end else if (live && !in_use_reg && pos_ext > commit.pos) begin
                    pos_reg <= pos_reg - 1'b1;
                end
            end
            CM_RELEASE: begin
                if (tgt) begin
                    in_use_reg <= 1'b0;
                    pos_reg    <= '0;
                end else if (live && !in_use_reg) begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            CM_NEW: begin
                if (tgt) begin
                    addr_reg   <= commit.addr;
                    size_reg   <= commit.size;
                    in_use_reg <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/ffa_ctrl.sv =====
// Request sequencer: handshakes, configuration, heap top and slot count.
`timescale 1ns / 1ps
module ffa_ctrl #(
    parameter int MAX_BLOCKS = 256,
    localparam int IW        = $clog2(MAX_BLOCKS),
    localparam int UW        = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [55:0]              s_tdata,
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [87:0]              m_tdata,
    output logic [2:0]               m_tuser,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0] cfg_wdata,
    input  ffa_pkg::token_t          tok_last,
    output ffa_pkg::query_t          query,
    output ffa_pkg::commit_t         commit,
    output logic [UW-1:0]            slots_used
);
    import ffa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     cnt_reg;
    query_t            query_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] ceil_reg;
    logic              started_reg;
    logic [ADDR_W-1:0] top_reg;
    logic [UW-1:0]     used_reg;
    logic              m_tvalid_reg;
    logic [87:0]       m_tdata_reg;
    status_t           m_status_reg;

    logic [ADDR_W-1:0] req_bytes;
    logic [N_W-1:0]    rounded;
    logic [N_W-1:0]    n_next;
    logic              out_free;

    logic [ADDR_W-1:0] eff_top;
    logic [N_W:0]      sum;
    logic              oom;
    logic [ADDR_W-1:0] res_addr;
    logic [ADDR_W-1:0] res_size;
    status_t           res_status;
    logic              started_next;
    logic [ADDR_W-1:0] top_next;
    logic [UW-1:0]     used_next;
    logic [ADDR_W-1:0] bytes_used;
    commit_t           commit_c;

    assign s_tready   = state_reg == S_IDLE;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign query      = query_reg;
    assign slots_used = used_reg;
    assign commit     = commit_c;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser    = m_status_reg;

    // Round the request up to a multiple of four, never below four.
    assign req_bytes = s_tdata[26:0];
    assign rounded   = ({1'b0, req_bytes} + N_W'(3)) & ~N_W'(3);
    assign n_next    = (rounded == '0) ? N_W'(4) : rounded;

    // Decision once the token has left the last cell.
    assign eff_top = started_reg ? top_reg : base_reg;
    assign sum     = {2'b00, eff_top} + {1'b0, query_reg.n} + (N_W + 1)'(HEADER_BYTES);
    assign oom     = sum > {2'b00, ceil_reg};

    always_comb begin
        res_addr        = '0;
        res_size        = '0;
        res_status      = ST_NULL;
        started_next    = started_reg;
        top_next        = top_reg;
        used_next       = used_reg;
        commit_c.op     = CM_NONE;
        commit_c.idx    = tok_last.idx;
        commit_c.pos    = tok_last.pos;
        commit_c.addr   = ADDR_W'(eff_top + ADDR_W'(HEADER_BYTES));
        commit_c.size   = query_reg.n[ADDR_W-1:0];
        if (query_reg.kind == REQ_ALLOC) begin
            started_next = 1'b1;
            top_next     = eff_top;
            if (tok_last.found) begin
                res_addr    = tok_last.addr;
                res_size    = tok_last.size;
                res_status  = ST_REUSED;
                commit_c.op = CM_REUSE;
            end else if (oom) begin
                res_status = ST_OOM;
            end else if (used_reg >= UW'(MAX_BLOCKS)) begin
                res_status = ST_FULL;
            end else begin
                res_addr     = commit_c.addr;
                res_size     = commit_c.size;
                res_status   = ST_NEW;
                top_next     = sum[ADDR_W-1:0];
                used_next    = used_reg + 1'b1;
                commit_c.op  = CM_NEW;
                commit_c.idx = IDX_MAX_W'(used_reg);
            end
        end else if (query_reg.a == '0) begin
            res_status = ST_NULL;
        end else if (tok_last.found && tok_last.in_use) begin
            res_status  = ST_FREED;
            commit_c.op = CM_RELEASE;
        end else begin
            res_status = ST_BAD;
        end
        if (!(state_reg == S_FINISH && out_free)) begin
            commit_c.op = CM_NONE;
        end
    end

    assign bytes_used = started_next ? ADDR_W'(top_next - base_reg) : '0;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            ceil_reg <= CEILING_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEAP_BASE:    base_reg <= cfg_wdata & ~ADDR_W'(3);
                CFG_HEAP_CEILING: ceil_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, heap state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            started_reg  <= 1'b0;
            top_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        query_reg.kind <= s_tuser;
                        query_reg.n    <= n_next;
                        query_reg.a    <= s_tdata[53:27];
                        cnt_reg        <= '0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IW'(MAX_BLOCKS - 1)) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        started_reg  <= started_next;
                        top_reg      <= top_next;
                        used_reg     <= used_next;
                        m_tdata_reg  <= {7'd0, bytes_used, res_size, res_addr};
                        m_status_reg <= res_status;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(MAX_BLOCKS))
        else $error("slot count beyond table size");

    a_finish_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free) |=> (state_reg == S_IDLE && m_tvalid_reg))
        else $error("result not issued after scan");

    a_commit_when: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_c.op != CM_NONE) |-> (state_reg == S_FINISH))
        else $error("cell update outside finish");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised without a finished scan");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the first-fit free list allocator: random and directed requests.
`timescale 1ns / 1ps
module tb_top;
    import ffa_pkg::*;

    localparam int NBLK      = DEF_MAX_BLOCKS;
    localparam int LIMIT     = 2000000;
    localparam int LONG_HOLD = 3000;
    localparam logic [26:0] W27 = 27'h7FFFFFF;

    // Expected content of one result.
    typedef struct {
        logic [26:0] addr;
        logic [26:0] size;
        status_t     status;
        logic [26:0] used;
    } grant_t;

    // Allocator state mirror plus the queue of grants still owed by the block.
    class alloc_scoreboard;
        logic [26:0] base_reg;
        logic [26:0] ceil_reg;
        bit          started;
        logic [26:0] top;
        int          head;
        int          nslots;
        logic [26:0] s_addr[NBLK];
        logic [26:0] s_size[NBLK];
        bit          s_busy[NBLK];
        int          s_next[NBLK];
        grant_t      owed[$];
        logic [26:0] granted[$];
        int          errors;

        function new();
            base_reg = 0;
            ceil_reg = CEILING_RESET;
            started  = 0;
            top      = 0;
            head     = NBLK;
            nslots   = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic idx, logic [26:0] val);
            if (idx == CFG_HEAP_BASE) base_reg = val & ~27'd3;
            else ceil_reg = val;
        endfunction

        function logic [26:0] bytes_used();
            if (!started) return 0;
            return (top - base_reg) & W27;
        endfunction

        function status_t allocate(logic [26:0] req, output logic [26:0] a,
                                   output logic [26:0] sz);
            longint n;
            int prev;
            int cur;
            int steps;
            n = (longint'(req) + 3) & ~longint'(3);
            prev = NBLK;
            cur = head;
            a = 0;
            sz = 0;
            if (n == 0) n = 4;
            if (!started) begin
                started = 1;
                top = base_reg;
            end
            // First fit over the free list.
            for (steps = 0; steps < NBLK && cur < nslots; steps++) begin
                if (longint'(s_size[cur]) >= n) begin
                    if (prev < NBLK) s_next[prev] = s_next[cur];
                    else head = s_next[cur];
                    s_busy[cur] = 1;
                    a = s_addr[cur];
                    sz = s_size[cur];
                    return ST_REUSED;
                end
                prev = cur;
                cur = s_next[cur];
            end
            if (longint'(top) + n + HEADER_BYTES > longint'(ceil_reg)) return ST_OOM;
            if (nslots >= NBLK) return ST_FULL;
            cur = nslots;
            nslots++;
            s_addr[cur] = 27'(top + 27'(HEADER_BYTES));
            s_size[cur] = n[26:0];
            s_busy[cur] = 1;
            s_next[cur] = NBLK;
            top = 27'(longint'(top) + n + HEADER_BYTES);
            a = s_addr[cur];
            sz = s_size[cur];
            return ST_NEW;
        endfunction

        function status_t release_blk(logic [26:0] a);
            int i;
            if (a == 0) return ST_NULL;
            for (i = 0; i < nslots; i++) begin
                if (s_addr[i] == a) begin
                    if (!s_busy[i]) return ST_BAD;
                    s_busy[i] = 0;
                    s_next[i] = head;
                    head = i;
                    return ST_FREED;
                end
            end
            return ST_BAD;
        endfunction

        // Called for every accepted request.
        function void note_request(logic kind, logic [26:0] req, logic [26:0] rel);
            grant_t g;
            if (kind == REQ_ALLOC) begin
                g.status = allocate(req, g.addr, g.size);
                if (g.status == ST_NEW || g.status == ST_REUSED) granted.push_back(g.addr);
            end else begin
                g.addr = 0;
                g.size = 0;
                g.status = release_blk(rel);
            end
            g.used = bytes_used();
            owed.push_back(g);
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        // Called for every accepted result.
        function void check_result(logic [26:0] a, logic [26:0] sz, logic [2:0] st,
                                   logic [26:0] used);
            grant_t g;
            if (owed.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            g = owed.pop_front();
            if (a !== g.addr) report($sformatf("payload_address %h want %h", a, g.addr));
            if (sz !== g.size) report($sformatf("granted_bytes %h want %h", sz, g.size));
            if (st !== g.status) report($sformatf("status %0d want %0d", st, g.status));
            if (used !== g.used) report($sformatf("heap_bytes_used %h want %h", used, g.used));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [26:0] cfg_wdata;

    alloc_scoreboard sb;
    int  cycles;
    bit  hold_req;

    first_fit_free_list_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // Observe both handshakes with pre-edge values.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[26:0], s_tdata[53:27]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[26:0], m_tdata[53:27], m_tuser, m_tdata[80:54]);
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("first_fit_free_list_allocator test failed");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold when asked.
    initial begin : receiver
        int gap;
        m_tready = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 6);
            if (hold_req) begin
                gap = LONG_HOLD;
                hold_req = 0;
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_request(logic kind, logic [26:0] req, logic [26:0] rel);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, rel, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic alloc_req(logic [26:0] req);
        send_request(REQ_ALLOC, req, 27'($urandom));
    endtask

    task automatic release_req(logic [26:0] rel);
        send_request(REQ_RELEASE, 27'($urandom), rel);
    endtask

    // Stop offering, wait for every owed result, then let the block settle.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.owed.size() > 0) @(posedge aclk);
        repeat (NBLK + 8) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [26:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // One random request, mostly well-formed alloc/release traffic.
    task automatic random_request();
        int r;
        logic [26:0] a;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if ($urandom_range(0, 49) == 0) alloc_req(27'($urandom));
            else alloc_req(27'($urandom_range(0, 200)));
        end else if (r < 85 && sb.granted.size() > 0) begin
            a = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
            release_req(a);
        end else if (r < 90) begin
            release_req(27'd0);
        end else if (r < 95 && sb.granted.size() > 0) begin
            a = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
            release_req(a + 27'd4);
        end else begin
            release_req(27'($urandom));
        end
    endtask

    initial begin : main
        int ph;
        logic [26:0] a0;
        logic [26:0] a3;
        sb = new();
        cycles = 0;
        hold_req = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = REQ_ALLOC;
        cfg_wr_en = 0;
        cfg_index = CFG_HEAP_BASE;
        cfg_wdata = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: minimum sizes, rounding, release cases and reuse.
        write_cfg(CFG_HEAP_BASE, 27'd4096);
        alloc_req(27'd0);
        alloc_req(27'd1);
        alloc_req(27'd5);
        alloc_req(27'd16);
        drain();
        a0 = sb.granted[0];
        a3 = sb.granted[3];
        release_req(a3);
        release_req(a3);
        release_req(27'd0);
        release_req(a0 + 27'd4);
        alloc_req(27'd12);
        alloc_req(W27);
        release_req(W27);
        release_req(a0);
        alloc_req(27'd2);
        drain();
        // Tight ceiling: one fits, a larger one runs out.
        write_cfg(CFG_HEAP_CEILING, sb.top + 27'd20);
        alloc_req(27'd100);
        alloc_req(27'd8);
        drain();
        // Unaligned base written after start: top stays, used bytes wrap.
        write_cfg(CFG_HEAP_BASE, W27);
        write_cfg(CFG_HEAP_CEILING, W27);
        alloc_req(27'd40);
        release_req(27'd0);
        drain();

        // Random phases over several settings.
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    write_cfg(CFG_HEAP_BASE, 27'd0);
                    write_cfg(CFG_HEAP_CEILING, CEILING_RESET);
                end
                1: begin
                    write_cfg(CFG_HEAP_BASE, 27'($urandom));
                    write_cfg(CFG_HEAP_CEILING, sb.top + 27'($urandom_range(0, 3000)));
                end
                2: begin
                    write_cfg(CFG_HEAP_BASE, 27'h7FFFFFC);
                    write_cfg(CFG_HEAP_CEILING, 27'd0);
                end
                default: begin
                    write_cfg(CFG_HEAP_BASE, 27'd3);
                    write_cfg(CFG_HEAP_CEILING, W27);
                end
            endcase
            if (ph == 1) hold_req = 1;
            repeat (85) random_request();
            drain();
        end

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("first_fit_free_list_allocator test passed");
        else
            $display("first_fit_free_list_allocator test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/ffa_pkg.sv
hdl/ffa_cell.sv
hdl/ffa_ctrl.sv
hdl/first_fit_free_list_allocator.sv
bench/tb_top.sv
